// ===== rtl/aat_pkg.sv =====
// Shared types and constants for the aging address table.
// No dependencies; compile first.
package aat_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int KIND_W     = 2;
	localparam int IP_W       = 32;
	localparam int STAMP_W    = 32;
	localparam int TIMEOUT_W  = 16;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1;

	localparam logic REG_TIMEOUT = 1'b0;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic [IP_W-1:0]    addr;
		logic [STAMP_W-1:0] stamp;
	} aat_entry_t;

	localparam int ENTRY_W = $bits(aat_entry_t);

endpackage

// ===== rtl/aat_if.sv =====
// Request and response channel interfaces of the aging address table.
// Depends on aat_pkg.
interface aat_req_if import aat_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IP_W-1:0]   ip_addr;

	modport source (output valid, output kind, output ip_addr, input ready);
	modport sink   (input valid, input kind, input ip_addr, output ready);
endinterface

interface aat_rsp_if import aat_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                hit;
	logic [COUNT_W-1:0]  expired_count;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output status, output hit, output expired_count,
		output entry_count, input ready);
	modport sink   (input valid, input status, input hit, input expired_count,
		input entry_count, output ready);
endinterface

// ===== rtl/aging_address_table_unit.sv =====
// Aging address table over one packed entry RAM; depends on aat_pkg, aat_if and aat_ram.
// Insert writes its entry on acceptance unless the table is full, then goes to finish; lookup,
// remove and tick scan the entries held before the transaction, one slot scanned per cycle.
// Throughput: one transaction at a time, the next taken the cycle after the result is
// registered; a result not yet taken on the response port holds the table in its finish state.
// Reset clears entry count, time and timeout (to 1); memory contents need no clearing.
module aging_address_table_unit import aat_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	aat_req_if.sink               req,
	aat_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = $clog2(TABLE_ENTRIES);

	state_t                 state_q;
	logic [CW-1:0]          cnt_q;
	logic [STAMP_W-1:0]     now_q;
	logic [TIMEOUT_W-1:0]   timeout_q;
	logic [CW-1:0]          rd_idx_q;
	logic [CW-1:0]          wr_idx_q;
	logic [CW-1:0]          exp_q;
	logic                   found_q;
	logic                   full_q;
	logic                   rd_s1;
	kind_t                  kind_q;
	logic [IP_W-1:0]        addr_q;

	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic                   out_hit_q;
	logic [COUNT_W-1:0]     out_exp_q;
	logic [COUNT_W-1:0]     out_cnt_q;

	logic                   in_fire;
	logic                   out_free;
	logic                   finish;
	logic                   full;
	logic                   rd_go;
	logic                   scan_done;
	logic                   match;
	logic                   expired;
	logic                   drop;
	logic                   keep_wr;
	logic                   ins_wr;
	logic [STAMP_W-1:0]     age;
	logic [CW-1:0]          new_cnt;
	logic [STATUS_W-1:0]    res_status;
	logic                   res_hit;
	logic [CW-1:0]          res_exp;
	aat_entry_t             rd_entry;
	aat_entry_t             ins_entry;
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic [ENTRY_W-1:0]     ram_wdata;
	logic [ENTRY_W-1:0]     ram_rdata;
	logic                   cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);
	assign prdata = (paddr[2] == REG_TIMEOUT) ?
		{{(APB_DATA_W-TIMEOUT_W){1'b0}}, timeout_q} : '0;

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign finish    = (state_q == ST_FINISH) && out_free;
	assign full      = (cnt_q == CW'(TABLE_ENTRIES));

	// scan datapath
	assign rd_go     = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
	assign scan_done = (state_q == ST_SCAN) && !rd_go && !rd_s1;
	assign rd_entry  = aat_entry_t'(ram_rdata);
	assign match     = (rd_entry.addr == addr_q);
	assign age       = now_q - rd_entry.stamp;
	assign expired   = (age >= {{(STAMP_W-TIMEOUT_W){1'b0}}, timeout_q});
	assign drop      = ((kind_q == KIND_REMOVE) && match && !found_q) ||
		((kind_q == KIND_TICK) && expired);
	assign keep_wr   = rd_s1 && ((kind_q == KIND_REMOVE) || (kind_q == KIND_TICK)) && !drop;

	assign ins_wr         = in_fire && (kind_t'(req.kind) == KIND_INSERT) && !full;
	assign ins_entry.addr  = req.ip_addr;
	assign ins_entry.stamp = now_q;

	always_comb begin
		if (ins_wr) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[IW-1:0];
			ram_wdata = ins_entry;
		end else begin
			ram_we    = keep_wr;
			ram_waddr = wr_idx_q[IW-1:0];
			ram_wdata = ram_rdata;
		end
	end

	aat_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_go),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// result
	always_comb begin
		new_cnt    = cnt_q;
		res_status = STATUS_OK;
		res_hit    = 1'b0;
		res_exp    = '0;
		case (kind_q)
			KIND_INSERT: begin
				if (full_q) begin
					res_status = STATUS_FULL;
				end
			end
			KIND_LOOKUP: begin
				res_hit = found_q;
			end
			KIND_REMOVE: begin
				new_cnt = wr_idx_q;
				res_hit = found_q;
				if (!found_q) begin
					res_status = STATUS_MISS;
				end
			end
			KIND_TICK: begin
				new_cnt = wr_idx_q;
				res_exp = exp_q;
			end
			default: begin
				new_cnt = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			now_q       <= '0;
			timeout_q   <= TIMEOUT_RESET;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			exp_q       <= '0;
			found_q     <= 1'b0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				timeout_q <= pwdata[TIMEOUT_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						rd_idx_q <= '0;
						wr_idx_q <= '0;
						exp_q    <= '0;
						found_q  <= 1'b0;
						rd_s1    <= 1'b0;
						if (ins_wr) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (kind_t'(req.kind) == KIND_TICK) begin
							now_q <= now_q + STAMP_W'(1);
						end
						state_q <= (kind_t'(req.kind) == KIND_INSERT) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_s1 <= rd_go;
					if (rd_go) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (keep_wr) begin
						wr_idx_q <= wr_idx_q + CW'(1);
					end
					if (rd_s1 && match && (kind_q != KIND_TICK)) begin
						found_q <= 1'b1;
					end
					if (rd_s1 && (kind_q == KIND_TICK) && expired) begin
						exp_q <= exp_q + CW'(1);
					end
					if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						cnt_q   <= new_cnt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind_t'(req.kind);
			addr_q <= req.ip_addr;
			full_q <= full;
		end
		if (finish) begin
			out_status_q <= res_status;
			out_hit_q    <= res_hit;
			out_exp_q    <= COUNT_W'(res_exp);
			out_cnt_q    <= COUNT_W'(new_cnt);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.hit           = out_hit_q;
	assign rsp.expired_count = out_exp_q;
	assign rsp.entry_count   = out_cnt_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_ENTRIES))
		else $error("entry count exceeds table size");

	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (wr_idx_q <= rd_idx_q))
		else $error("compaction write pointer passed read pointer");

	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (kind_t'(req.kind) == KIND_TICK)) |=> (now_q == $past(now_q) + STAMP_W'(1)))
		else $error("tick did not advance time");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= cnt_q))
		else $error("scan read past valid entries");
`endif

endmodule

// ===== rtl/aat_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module aat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
